// ===== sv/svpwm_pkg.sv =====
// Shared types, codes and constant tables for the SVPWM vector sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package svpwm_pkg;

    localparam int unsigned TABLE_DEGREES = 360;
    localparam logic [15:0] PERIOD_RESET  = 16'd1536;
    localparam logic [8:0]  MAG_LIMIT     = 9'd256;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SWITCH = 1'b1;

    typedef enum logic [1:0] {
        ZONE_ZERO   = 2'd0,
        ZONE_FIRST  = 2'd1,
        ZONE_SECOND = 2'd2
    } zone_t;

    typedef struct packed {
        logic       operation;
        logic [8:0] angle_deg;
        logic [8:0] magnitude;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  high_side_on;
        logic [2:0]  low_side_on;
        logic [2:0]  vector_index;
        logic [15:0] reload_value;
    } rsp_item_t;

    typedef struct packed {
        logic        angle_ok;
        logic [10:0] first_time;
        logic [10:0] second_time;
        logic [15:0] zero_time;
        logic [2:0]  sector;
        logic        half_flag;
    } dwell_t;

    // round(256*sin(k deg)) for k = 0..60
    function automatic logic [7:0] sine_lut(input logic [5:0] k);
        logic [7:0] s;
        case (k)
            6'd0:  s = 8'd0;   6'd1:  s = 8'd4;   6'd2:  s = 8'd9;   6'd3:  s = 8'd13;
            6'd4:  s = 8'd18;  6'd5:  s = 8'd22;  6'd6:  s = 8'd27;  6'd7:  s = 8'd31;
            6'd8:  s = 8'd36;  6'd9:  s = 8'd40;  6'd10: s = 8'd44;  6'd11: s = 8'd49;
            6'd12: s = 8'd53;  6'd13: s = 8'd58;  6'd14: s = 8'd62;  6'd15: s = 8'd66;
            6'd16: s = 8'd71;  6'd17: s = 8'd75;  6'd18: s = 8'd79;  6'd19: s = 8'd83;
            6'd20: s = 8'd88;  6'd21: s = 8'd92;  6'd22: s = 8'd96;  6'd23: s = 8'd100;
            6'd24: s = 8'd104; 6'd25: s = 8'd108; 6'd26: s = 8'd112; 6'd27: s = 8'd116;
            6'd28: s = 8'd120; 6'd29: s = 8'd124; 6'd30: s = 8'd128; 6'd31: s = 8'd132;
            6'd32: s = 8'd136; 6'd33: s = 8'd139; 6'd34: s = 8'd143; 6'd35: s = 8'd147;
            6'd36: s = 8'd150; 6'd37: s = 8'd154; 6'd38: s = 8'd158; 6'd39: s = 8'd161;
            6'd40: s = 8'd165; 6'd41: s = 8'd168; 6'd42: s = 8'd171; 6'd43: s = 8'd175;
            6'd44: s = 8'd178; 6'd45: s = 8'd181; 6'd46: s = 8'd184; 6'd47: s = 8'd187;
            6'd48: s = 8'd190; 6'd49: s = 8'd193; 6'd50: s = 8'd196; 6'd51: s = 8'd199;
            6'd52: s = 8'd202; 6'd53: s = 8'd204; 6'd54: s = 8'd207; 6'd55: s = 8'd210;
            6'd56: s = 8'd212; 6'd57: s = 8'd215; 6'd58: s = 8'd217; 6'd59: s = 8'd219;
            6'd60: s = 8'd222;
            default: s = 8'd0;
        endcase
        return s;
    endfunction

    // first active vector of a sector, zero when there is no sector
    function automatic logic [2:0] vec_a(input logic [2:0] sector);
        logic [2:0] v;
        case (sector)
            3'd1:    v = 3'd4;
            3'd2:    v = 3'd2;
            3'd3:    v = 3'd2;
            3'd4:    v = 3'd1;
            3'd5:    v = 3'd1;
            3'd6:    v = 3'd4;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] vec_b(input logic [2:0] sector);
        logic [2:0] v;
        case (sector)
            3'd1:    v = 3'd6;
            3'd2:    v = 3'd6;
            3'd3:    v = 3'd3;
            3'd4:    v = 3'd3;
            3'd5:    v = 3'd5;
            3'd6:    v = 3'd5;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // distance from 60 of (d mod 120), for d up to 479
    function automatic logic [5:0] tab_index(input logic [8:0] d);
        logic [8:0] r;
        r = d;
        if (r >= 9'd240) r = r - 9'd240;
        if (r >= 9'd120) r = r - 9'd120;
        return (r <= 9'd60) ? 6'(9'd60 - r) : 6'(r - 9'd60);
    endfunction

endpackage

`default_nettype wire

// ===== sv/svpwm_dwell.sv =====
// Dwell-time, sector and half-sector calculation for one load item.
// Depends on svpwm_pkg (sine table, dwell_t).
`default_nettype none

module svpwm_dwell (
    input  wire logic [8:0]        angle_deg,
    input  wire logic [8:0]        magnitude,
    input  wire logic [15:0]       period_ticks,
    output svpwm_pkg::dwell_t      dwell
);
    import svpwm_pkg::*;

    logic [8:0]  mag_sat;
    logic [10:0] mag_x3;
    logic [7:0]  mag_scaled;
    logic [8:0]  angle_plus;
    logic [7:0]  sin_first;
    logic [7:0]  sin_second;
    logic [15:0] prod_first;
    logic [15:0] prod_second;
    logic [11:0] active_sum;
    logic [8:0]  sector_base;
    logic [5:0]  offset;

    always_comb
    begin
        mag_sat    = (magnitude > MAG_LIMIT) ? MAG_LIMIT : magnitude;
        mag_x3     = {1'b0, mag_sat, 1'b0} + {2'b00, mag_sat};
        mag_scaled = mag_x3[9:2];

        angle_plus = angle_deg + 9'd60;
        sin_first  = sine_lut(tab_index(angle_deg));
        sin_second = sine_lut(tab_index(angle_plus));

        prod_first  = sin_first * mag_scaled;
        prod_second = sin_second * mag_scaled;

        dwell.angle_ok    = ({23'd0, angle_deg} < 32'(TABLE_DEGREES));
        dwell.first_time  = prod_first[15:5];
        dwell.second_time = prod_second[15:5];

        // saturate at zero when the active vectors fill the period
        active_sum = {1'b0, prod_first[15:5]} + {1'b0, prod_second[15:5]};
        dwell.zero_time = ({4'd0, active_sum} > period_ticks) ? 16'd0
                        : period_ticks - {4'd0, active_sum};

        if (angle_deg >= 9'd300)      begin dwell.sector = 3'd6; sector_base = 9'd300; end
        else if (angle_deg >= 9'd240) begin dwell.sector = 3'd5; sector_base = 9'd240; end
        else if (angle_deg >= 9'd180) begin dwell.sector = 3'd4; sector_base = 9'd180; end
        else if (angle_deg >= 9'd120) begin dwell.sector = 3'd3; sector_base = 9'd120; end
        else if (angle_deg >= 9'd60)  begin dwell.sector = 3'd2; sector_base = 9'd60;  end
        else                          begin dwell.sector = 3'd1; sector_base = 9'd0;   end

        offset = 6'(angle_deg - sector_base);
        // odd sectors: past the middle; even sectors: before the middle
        dwell.half_flag = dwell.sector[0] ? (offset > 6'd30) : (offset < 6'd30);
    end

endmodule

`default_nettype wire

// ===== sv/svpwm_zone.sv =====
// Sequencer state: dwell times, sector, zone and the pending vector.
// Depends on svpwm_pkg (zone_t, dwell_t, rsp_item_t, vector tables).
`default_nettype none

module svpwm_zone (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_en,
    input  wire logic              switch_en,
    input  wire svpwm_pkg::dwell_t dwell,
    output svpwm_pkg::rsp_item_t   pending
);
    import svpwm_pkg::*;

    zone_t       zone_reg,          zone_next;
    logic [2:0]  vector_reg,        vector_next;
    logic [15:0] reload_reg,        reload_next;
    logic [10:0] first_time_reg,    first_time_next;
    logic [10:0] second_time_reg,   second_time_next;
    logic [15:0] zero_time_reg,     zero_time_next;
    logic [2:0]  sector_reg,        sector_next;
    logic        half_reg,          half_next;
    logic        use_a;
    logic [10:0] active_time;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg        <= ZONE_ZERO;
            vector_reg      <= 3'd0;
            reload_reg      <= 16'd0;
            first_time_reg  <= 11'd0;
            second_time_reg <= 11'd0;
            zero_time_reg   <= 16'd0;
            sector_reg      <= 3'd0;
            half_reg        <= 1'b0;
        end
        else
        begin
            zone_reg        <= zone_next;
            vector_reg      <= vector_next;
            reload_reg      <= reload_next;
            first_time_reg  <= first_time_next;
            second_time_reg <= second_time_next;
            zero_time_reg   <= zero_time_next;
            sector_reg      <= sector_next;
            half_reg        <= half_next;
        end
    end

    always_comb
    begin
        zone_next        = zone_reg;
        vector_next      = vector_reg;
        reload_next      = reload_reg;
        first_time_next  = first_time_reg;
        second_time_next = second_time_reg;
        zero_time_next   = zero_time_reg;
        sector_next      = sector_reg;
        half_next        = half_reg;
        use_a            = 1'b0;
        active_time      = 11'd0;

        if (load_en)
        begin
            first_time_next  = dwell.first_time;
            second_time_next = dwell.second_time;
            zero_time_next   = dwell.zero_time;
            sector_next      = dwell.sector;
            half_next        = dwell.half_flag;
        end

        if (switch_en)
        begin
            case (zone_reg)
                ZONE_ZERO:  zone_next = ZONE_FIRST;
                ZONE_FIRST: zone_next = ZONE_SECOND;
                default:    zone_next = ZONE_ZERO;
            endcase

            use_a       = (zone_next == ZONE_FIRST) ? half_reg : !half_reg;
            active_time = use_a ? first_time_reg : second_time_reg;

            if (zone_next == ZONE_ZERO)
            begin
                vector_next = 3'd0;
                reload_next = ~zero_time_reg;
            end
            else
            begin
                // hold the vector when no angle has been loaded yet
                if (sector_reg != 3'd0 && sector_reg != 3'd7)
                    vector_next = use_a ? vec_a(sector_reg) : vec_b(sector_reg);
                reload_next = ~{5'd0, active_time};
            end
        end
    end

    assign pending.high_side_on = vector_reg;
    assign pending.low_side_on  = ~vector_reg;
    assign pending.vector_index = vector_reg;
    assign pending.reload_value = reload_reg;

endmodule

`default_nettype wire

// ===== sv/svpwm_vector_sequencer.sv =====
// Top level of the SVPWM vector sequencer: input register, period register,
// result register. Depends on svpwm_pkg, svpwm_dwell and svpwm_zone.
`default_nettype none

// One item a cycle while results are taken: an item is registered at the input
// and processed against the sequencer state from there; a switch item waits
// there while the result register is full, and its result is loaded into the
// result register when it is processed, raising rsp_valid. Load items
// (operation 0) update the dwell times and sector and give no result; a load
// with an angle of 360 or more is dropped. The result register lets a new
// item in while a result waits for rsp_ready, so the throughput is one item
// per clock as long as results are taken. The PWM period (cfg_data, reset
// 1536 ticks) is written by the user with cfg_we while idle; not enforced.
module svpwm_vector_sequencer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [15:0]           cfg_data,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire svpwm_pkg::req_item_t  req_item,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output svpwm_pkg::rsp_item_t       rsp_item
);
    import svpwm_pkg::*;

    logic [15:0] period_reg;
    logic        stage_valid_reg;
    req_item_t   stage_item_reg;
    logic        rsp_valid_reg;
    rsp_item_t   rsp_item_reg;

    logic        rsp_free;
    logic        stage_is_switch;
    logic        stage_fire;
    logic        load_en;
    logic        switch_en;
    dwell_t      dwell;
    rsp_item_t   pending;

    assign rsp_free        = !rsp_valid_reg || rsp_ready;
    assign stage_is_switch = (stage_item_reg.operation == OP_SWITCH);
    // a load gives no result, so it never waits on the output
    assign stage_fire      = stage_valid_reg && (!stage_is_switch || rsp_free);
    assign req_ready       = !stage_valid_reg || stage_fire;
    assign load_en         = stage_fire && !stage_is_switch && dwell.angle_ok;
    assign switch_en       = stage_fire && stage_is_switch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= PERIOD_RESET;
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                period_reg <= cfg_data;
            if (req_ready)
                stage_valid_reg <= req_valid;
            if (switch_en)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            stage_item_reg <= req_item;
        if (switch_en)
            rsp_item_reg <= pending;
    end

    svpwm_dwell u_dwell (
        .angle_deg    (stage_item_reg.angle_deg),
        .magnitude    (stage_item_reg.magnitude),
        .period_ticks (period_reg),
        .dwell        (dwell)
    );

    svpwm_zone u_zone (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (load_en),
        .switch_en (switch_en),
        .dwell     (dwell),
        .pending   (pending)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

`default_nettype wire

// ===== bench/tb_svpwm_vector_sequencer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for svpwm_vector_sequencer: directed items, then random
// phases over several PWM periods, checked against an in-bench dwell/vector predictor.
// Depends on svpwm_pkg and svpwm_vector_sequencer.

module tb_svpwm_vector_sequencer;

    import svpwm_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_COUNT     = 7;
    localparam int PHASE_ITEMS     = 140;
    localparam int DIRECTED_ROWS   = 25;
    localparam int SETTLE_CYCLES   = 6;

    // round(256*sin(k deg)), k = 0..60
    localparam logic [0:60][7:0] SINE_TAB = {
        8'd0,   8'd4,   8'd9,   8'd13,  8'd18,  8'd22,  8'd27,  8'd31,  8'd36,  8'd40,
        8'd44,  8'd49,  8'd53,  8'd58,  8'd62,  8'd66,  8'd71,  8'd75,  8'd79,  8'd83,
        8'd88,  8'd92,  8'd96,  8'd100, 8'd104, 8'd108, 8'd112, 8'd116, 8'd120, 8'd124,
        8'd128, 8'd132, 8'd136, 8'd139, 8'd143, 8'd147, 8'd150, 8'd154, 8'd158, 8'd161,
        8'd165, 8'd168, 8'd171, 8'd175, 8'd178, 8'd181, 8'd184, 8'd187, 8'd190, 8'd193,
        8'd196, 8'd199, 8'd202, 8'd204, 8'd207, 8'd210, 8'd212, 8'd215, 8'd217, 8'd219,
        8'd222
    };
    localparam logic [0:6][2:0] FIRST_VEC  = {3'd0, 3'd4, 3'd2, 3'd2, 3'd1, 3'd1, 3'd4};
    localparam logic [0:6][2:0] SECOND_VEC = {3'd0, 3'd6, 3'd6, 3'd3, 3'd3, 3'd5, 3'd5};

    typedef struct packed {
        req_item_t item;
        logic      checked;
        rsp_item_t golden;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [15:0] cfg_data;
    logic      req_valid;
    logic      req_ready;
    req_item_t req_item;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp_item;

    // tags that travel with the offered item
    logic      stim_checked;
    rsp_item_t stim_golden;

    rsp_item_t expected_vectors [$];
    int        fail_count = 0;
    int        hold_off_asked = 0;
    int        cycle_count = 0;

    // predictor state
    logic [15:0] model_period = PERIOD_RESET;
    zone_t       model_zone = ZONE_ZERO;
    logic [2:0]  model_vec = 3'd0;
    logic [15:0] model_reload = 16'd0;
    logic [10:0] model_first = 11'd0;
    logic [10:0] model_second = 11'd0;
    logic [15:0] model_zero = 16'd0;
    logic [2:0]  model_sector = 3'd0;
    logic        model_half = 1'b0;

    svpwm_vector_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] sine_at(input int unsigned d);
        int unsigned r;
        int unsigned k;
        r = d % 120;
        k = (r <= 60) ? 60 - r : r - 60;
        return SINE_TAB[k];
    endfunction

    // Advance the sequencer predictor by one item; a switch yields the vector it applies.
    task automatic predict_vector(input req_item_t it, output bit emits, output rsp_item_t r);
        int unsigned d;
        int unsigned m;
        int unsigned sum;
        logic [15:0] dwell;
        logic        use_first;
        emits = 1'b0;
        r = '0;
        if (it.operation == OP_LOAD)
        begin
            d = 32'(it.angle_deg);
            m = 32'(it.magnitude);
            if (d < TABLE_DEGREES)
            begin
                if (m > 32'(MAG_LIMIT)) m = 32'(MAG_LIMIT);
                m = (m * 3) / 4;
                model_first  = 11'((32'(sine_at(d)) * m) >> 5);
                model_second = 11'((32'(sine_at(d + 60)) * m) >> 5);
                sum = 32'(model_first) + 32'(model_second);
                model_zero = (sum > 32'(model_period)) ? 16'd0
                           : 16'(32'(model_period) - sum);
                model_sector = 3'(d / 60 + 1);
                case (model_sector)
                    3'd1:    model_half = d > 30;
                    3'd2:    model_half = d < 90;
                    3'd3:    model_half = d > 150;
                    3'd4:    model_half = d < 210;
                    3'd5:    model_half = d > 270;
                    default: model_half = d < 330;
                endcase
            end
        end
        else
        begin
            emits = 1'b1;
            r.high_side_on = model_vec;
            r.low_side_on  = ~model_vec;
            r.vector_index = model_vec;
            r.reload_value = model_reload;
            case (model_zone)
                ZONE_ZERO:  model_zone = ZONE_FIRST;
                ZONE_FIRST: model_zone = ZONE_SECOND;
                default:    model_zone = ZONE_ZERO;
            endcase
            if (model_zone == ZONE_ZERO)
            begin
                model_vec = 3'd0;
                dwell = model_zero;
            end
            else
            begin
                use_first = (model_zone == ZONE_FIRST) ? model_half : !model_half;
                // hold the previous vector until a sector is known
                if (model_sector >= 3'd1 && model_sector <= 3'd6)
                    model_vec = use_first ? FIRST_VEC[model_sector] : SECOND_VEC[model_sector];
                dwell = use_first ? 16'(model_first) : 16'(model_second);
            end
            model_reload = ~dwell;
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        bit        emits;
        rsp_item_t predicted;
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_vectors.size() == 0)
                begin
                    $error("result with no item outstanding: vector_index %0d",
                           rsp_item.vector_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_vectors.pop_front();
                    compare_field("high_side_on", 16'(want.high_side_on),
                                  16'(rsp_item.high_side_on));
                    compare_field("low_side_on", 16'(want.low_side_on),
                                  16'(rsp_item.low_side_on));
                    compare_field("vector_index", 16'(want.vector_index),
                                  16'(rsp_item.vector_index));
                    compare_field("reload_value", want.reload_value, rsp_item.reload_value);
                end
            end
            if (req_valid && req_ready)
            begin
                predict_vector(req_item, emits, predicted);
                if (emits)
                    expected_vectors.push_back(stim_checked ? stim_golden : predicted);
            end
            if (cfg_we)
                model_period = cfg_data;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** svpwm_vector_sequencer: FAILED **");
            $finish;
        end
    end

    // Directed items: {op, angle, magnitude, checked, high, low, vector, reload}
    function automatic dir_row_t directed_row(input int i);
        dir_row_t row;
        case (i)
            // no sector yet after reset
            0:  row = {OP_SWITCH, 9'h1FF, 9'h1FF, 1'b1, 3'd0, 3'd7, 3'd0, 16'h0000};
            1:  row = {OP_SWITCH, 9'd0,   9'd0,   1'b1, 3'd0, 3'd7, 3'd0, 16'hFFFF};
            2:  row = {OP_SWITCH, 9'd0,   9'd0,   1'b1, 3'd0, 3'd7, 3'd0, 16'hFFFF};
            3:  row = {OP_LOAD,   9'd0,   9'd256, 1'b0, 25'd0};
            4:  row = {OP_SWITCH, 9'd0,   9'd0,   1'b1, 3'd0, 3'd7, 3'd0, 16'hFFFF};
            5:  row = {OP_SWITCH, 9'd0,   9'd0,   1'b1, 3'd6, 3'd1, 3'd6, 16'hFFFF};
            6:  row = {OP_SWITCH, 9'd0,   9'd0,   1'b1, 3'd4, 3'd3, 3'd4, 16'hFACB};
            7:  row = {OP_SWITCH, 9'd0,   9'd0,   1'b1, 3'd0, 3'd7, 3'd0, 16'hFF33};
            // out-of-range angles leave everything as it was
            8:  row = {OP_LOAD,   9'd360, 9'd100, 1'b0, 25'd0};
            9:  row = {OP_LOAD,   9'h1FF, 9'h1FF, 1'b0, 25'd0};
            10: row = {OP_SWITCH, 9'd0,   9'd0,   1'b1, 3'd6, 3'd1, 3'd6, 16'hFFFF};
            11: row = {OP_LOAD,   9'd359, 9'h1FF, 1'b0, 25'd0};
            12: row = {OP_SWITCH, 9'h155, 9'h0AA, 1'b0, 25'd0};
            13: row = {OP_SWITCH, 9'h0AA, 9'h155, 1'b0, 25'd0};
            14: row = {OP_SWITCH, 9'd0,   9'd0,   1'b0, 25'd0};
            15: row = {OP_LOAD,   9'd30,  9'd256, 1'b0, 25'd0};
            16: row = {OP_LOAD,   9'd31,  9'd200, 1'b0, 25'd0};
            17: row = {OP_SWITCH, 9'd0,   9'd0,   1'b0, 25'd0};
            18: row = {OP_SWITCH, 9'd0,   9'd0,   1'b0, 25'd0};
            19: row = {OP_SWITCH, 9'd0,   9'd0,   1'b0, 25'd0};
            20: row = {OP_LOAD,   9'd90,  9'd0,   1'b0, 25'd0};
            21: row = {OP_SWITCH, 9'd0,   9'd0,   1'b0, 25'd0};
            22: row = {OP_SWITCH, 9'd0,   9'd0,   1'b0, 25'd0};
            23: row = {OP_LOAD,   9'd150, 9'd257, 1'b0, 25'd0};
            default: row = {OP_SWITCH, 9'd0, 9'd0, 1'b0, 25'd0};
        endcase
        return row;
    endfunction

    function automatic req_item_t random_item(output bit ignored);
        req_item_t it;
        int        pick;
        pick = int'($urandom_range(0, 99));
        ignored = 1'b0;
        it.angle_deg = 9'($urandom_range(0, 359));
        it.magnitude = 9'($urandom_range(0, 256));
        if (pick < 25)
        begin
            it.operation = OP_LOAD;
            case ($urandom_range(0, 5))
                0:       it.magnitude = MAG_LIMIT;
                1:       it.magnitude = 9'($urandom_range(257, 511));
                default: ;
            endcase
        end
        else if (pick < 30)
        begin
            it.operation = OP_LOAD;
            it.angle_deg = 9'($urandom_range(360, 511));
            it.magnitude = 9'($urandom_range(0, 511));
            ignored = 1'b1;
        end
        else
        begin
            it.operation = OP_SWITCH;
            it.angle_deg = 9'($urandom_range(0, 511));
            it.magnitude = 9'($urandom_range(0, 511));
        end
        return it;
    endfunction

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input req_item_t it, input logic checked, input rsp_item_t golden);
        req_valid    <= 1'b1;
        req_item     <= it;
        stim_checked <= checked;
        stim_golden  <= golden;
        @(posedge clk);
        while (!(req_valid && req_ready)) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (expected_vectors.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(input int count);
        int        done;
        int        burst;
        int        gap;
        bit        ignored;
        req_item_t it;
        done = 0;
        while (done < count)
        begin
            burst = int'($urandom_range(1, 12));
            repeat (burst)
            begin
                it = random_item(ignored);
                send_item(it, 1'b0, '0);
                if (!ignored) done++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap != 0) idle_sender(gap);
        end
    endtask

    function automatic logic [15:0] phase_period(input int p);
        case (p)
            1:       return 16'd0;
            2:       return 16'hFFFF;
            3:       return 16'd1;
            4:       return 16'($urandom_range(2, 65534));
            5:       return 16'd800;
            default: return PERIOD_RESET;
        endcase
    endfunction

    initial
    begin : receiver
        int run_len;
        int stall_len;
        int served;
        served = 0;
        rsp_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off_asked > served)
            begin
                // hold off long enough for the block to back up into its input
                served++;
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
            begin
                run_len = ($urandom_range(0, 7) == 0) ? 40 : int'($urandom_range(0, 15));
                if (run_len != 0)
                begin
                    rsp_ready <= 1'b1;
                    repeat (run_len) @(negedge clk);
                end
                stall_len = int'($urandom_range(1, 5));
                rsp_ready <= 1'b0;
                repeat (stall_len) @(negedge clk);
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t row;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = 16'd0;
        req_valid    = 1'b0;
        req_item     = '0;
        stim_checked = 1'b0;
        stim_golden  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_row(i);
            send_item(row.item, row.checked, row.golden);
            if ($urandom_range(0, 2) == 0) idle_sender(int'($urandom_range(1, 3)));
        end
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p != 0)
            begin
                cfg_we   <= 1'b1;
                cfg_data <= phase_period(p);
                @(negedge clk);
                cfg_we   <= 1'b0;
                @(negedge clk);
            end
            if (p == 2 || p == 5) hold_off_asked++;
            run_random(PHASE_ITEMS);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_vectors.size() == 0)
            $display("** svpwm_vector_sequencer: PASSED **");
        else
            $display("** svpwm_vector_sequencer: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/svpwm_pkg.sv
sv/svpwm_dwell.sv
sv/svpwm_zone.sv
sv/svpwm_vector_sequencer.sv
bench/tb_svpwm_vector_sequencer.sv
